@@ rtl/msgenc_pkg.sv @@
// ----------------------------------------------------------------------------
// msgenc_pkg
// Shared types and codes of the MessagePack item encoder.
// ----------------------------------------------------------------------------
package msgenc_pkg;

  // item kinds on the input channel
  localparam logic [2:0] OpUint    = 3'd0;
  localparam logic [2:0] OpF32     = 3'd1;
  localparam logic [2:0] OpStrHdr  = 3'd2;
  localparam logic [2:0] OpStrByte = 3'd3;
  localparam logic [2:0] OpArrHdr  = 3'd4;
  localparam logic [2:0] OpMapHdr  = 3'd5;

  // format markers
  localparam logic [7:0] MarkU8    = 8'hcc;
  localparam logic [7:0] MarkU16   = 8'hcd;
  localparam logic [7:0] MarkU32   = 8'hce;
  localparam logic [7:0] MarkU64   = 8'hcf;
  localparam logic [7:0] MarkF32   = 8'hca;
  localparam logic [7:0] MarkStr8  = 8'hd9;
  localparam logic [7:0] MarkStr16 = 8'hda;
  localparam logic [7:0] MarkStr32 = 8'hdb;
  localparam logic [7:0] MarkArr16 = 8'hdc;
  localparam logic [7:0] MarkArr32 = 8'hdd;
  localparam logic [7:0] MarkMap16 = 8'hde;
  localparam logic [7:0] MarkMap32 = 8'hdf;
  localparam logic [7:0] FixStr    = 8'ha0;
  localparam logic [7:0] FixArr    = 8'h90;
  localparam logic [7:0] FixMap    = 8'h80;

  // longest encoding: marker plus eight bytes
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned FrameW   = MaxBytes * 8;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

endpackage

@@ rtl/msgpack_item_encoder.sv @@
// ----------------------------------------------------------------------------
// msgpack_item_encoder
// Encodes one MessagePack element per input transfer into a byte stream.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  input    | in        | in_valid_i / in_ready_o   | in_data_i  (op, value)
//  output   | out       | out_valid_o / out_ready_i | out_data_o (out_byte, last)
//
//  an item waits in the input register, then its whole encoding (1 to 9 bytes) is built
//  in one pass and loaded into the frame register
//  one byte leaves per cycle while out_ready_i is high; the next frame loads as the last
//  byte of the current one leaves
//  reset clears the valid flags and the byte count; payload registers keep junk
//  a stalled output holds its byte; one more item waits in the input register
//
module msgpack_item_encoder
  import msgenc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  in_t         s1_data_q;

  // frame register: encoded bytes left aligned, count of bytes still to send
  logic              frame_valid_q, frame_valid_d;
  logic [FrameW-1:0] frame_data_q, frame_data_d;
  logic [CntW-1:0]   frame_cnt_q, frame_cnt_d;

  // encoder result for the item in the input register
  logic [FrameW-1:0] enc_data;
  logic [CntW-1:0]   enc_cnt;

  logic        out_xfer, frame_done, frame_free, s1_adv, in_xfer;
  logic [63:0] val;
  logic [31:0] len;

  assign val = s1_data_q.value;
  assign len = val[31:0];

  // single pass encoder: marker and big-endian body, left aligned
  always_comb begin
    enc_data = '0;
    enc_cnt  = '0;
    unique case (s1_data_q.op)
      OpUint: begin
        priority if (val < 64'h80) begin
          enc_data = {val[7:0], 64'h0};
          enc_cnt  = CntW'(1);
        end else if (val <= 64'hff) begin
          enc_data = {MarkU8, val[7:0], 56'h0};
          enc_cnt  = CntW'(2);
        end else if (val <= 64'hffff) begin
          enc_data = {MarkU16, val[15:0], 48'h0};
          enc_cnt  = CntW'(3);
        end else if (val <= 64'hffff_ffff) begin
          enc_data = {MarkU32, val[31:0], 32'h0};
          enc_cnt  = CntW'(5);
        end else begin
          enc_data = {MarkU64, val};
          enc_cnt  = CntW'(9);
        end
      end
      OpF32: begin
        enc_data = {MarkF32, val[31:0], 32'h0};
        enc_cnt  = CntW'(5);
      end
      OpStrHdr: begin
        priority if (len < 32'd32) begin
          enc_data = {FixStr | {3'b000, len[4:0]}, 64'h0};
          enc_cnt  = CntW'(1);
        end else if (len <= 32'hff) begin
          enc_data = {MarkStr8, len[7:0], 56'h0};
          enc_cnt  = CntW'(2);
        end else if (len <= 32'hffff) begin
          enc_data = {MarkStr16, len[15:0], 48'h0};
          enc_cnt  = CntW'(3);
        end else begin
          enc_data = {MarkStr32, len, 32'h0};
          enc_cnt  = CntW'(5);
        end
      end
      OpStrByte: begin
        enc_data = {val[7:0], 64'h0};
        enc_cnt  = CntW'(1);
      end
      OpArrHdr, OpMapHdr: begin
        priority if (len < 32'd16) begin
          enc_data = {((s1_data_q.op == OpArrHdr) ? FixArr : FixMap) | {4'b0000, len[3:0]},
                      64'h0};
          enc_cnt  = CntW'(1);
        end else if (len <= 32'hffff) begin
          enc_data = {(s1_data_q.op == OpArrHdr) ? MarkArr16 : MarkMap16, len[15:0], 48'h0};
          enc_cnt  = CntW'(3);
        end else begin
          enc_data = {(s1_data_q.op == OpArrHdr) ? MarkArr32 : MarkMap32, len, 32'h0};
          enc_cnt  = CntW'(5);
        end
      end
      default: begin
        // unused kinds encode to nothing and are dropped
        enc_data = '0;
        enc_cnt  = '0;
      end
    endcase
  end

  // handshake
  assign out_xfer   = frame_valid_q & out_ready_i;
  assign frame_done = out_xfer & (frame_cnt_q == CntW'(1));
  assign frame_free = ~frame_valid_q | frame_done;
  assign s1_adv     = s1_valid_q & frame_free;
  assign in_ready_o = ~s1_valid_q | frame_free;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    frame_valid_d = frame_valid_q;
    frame_data_d  = frame_data_q;
    frame_cnt_d   = frame_cnt_q;
    if (s1_adv) begin
      frame_valid_d = (enc_cnt != '0);
      frame_data_d  = enc_data;
      frame_cnt_d   = enc_cnt;
    end else if (out_xfer) begin
      // next byte moves to the top
      frame_valid_d = ~frame_done;
      frame_data_d  = {frame_data_q[FrameW-9:0], 8'h0};
      frame_cnt_d   = frame_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      frame_valid_q <= 1'b0;
      frame_cnt_q   <= '0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      frame_valid_q <= frame_valid_d;
      frame_cnt_q   <= frame_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    frame_data_q <= frame_data_d;
  end

  assign out_valid_o         = frame_valid_q;
  assign out_data_o.out_byte = frame_data_q[FrameW-1 -: 8];
  assign out_data_o.last     = (frame_cnt_q == CntW'(1));

endmodule

@@ rtl/msgenc_checker.sv @@
// ----------------------------------------------------------------------------
// msgenc_checker
// Port-level checks of the MessagePack item encoder, bound to the top level.
// ----------------------------------------------------------------------------
module msgenc_checker
  import msgenc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a stalled byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output byte changed");

  // bytes of one item leave without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside an encoded item");

  // an empty output side never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no byte pending");

  // a valid item entering an idle output reaches it via the input and frame registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && (in_data_i.op <= OpMapHdr)
    |-> ##2 out_valid_o)
    else $error("item did not reach the output");

endmodule

bind msgpack_item_encoder msgenc_checker u_msgenc_checker (.*);
